/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL
// Concurrent assertion wrappers clocked on clk_i, with or without reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define FPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every rising edge, reset included.
`define FPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hw/rtl/fpa_pkg.sv */
// ---------------------------------------------------------------------------
// Fixed-point ALU package
// Operation codes and request/response payload types.
// ---------------------------------------------------------------------------
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } fpa_op_e;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_req_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               compare_true;
    logic               divide_by_zero;
  } fpa_rsp_t;

endpackage

/* hw/rtl/fpa_div_step.sv */
// ---------------------------------------------------------------------------
// Fixed-point ALU divider step
// One restoring division stage: one quotient bit per register stage.
// ---------------------------------------------------------------------------
module fpa_div_step import fpa_pkg::*; #(
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 40,
  parameter int unsigned TW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [QW-1:0] n_i,
  input  logic [DW-1:0] r_i,
  input  logic [DW-1:0] d_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [QW-1:0] n_o,
  output logic [DW-1:0] r_o,
  output logic [DW-1:0] d_o,
  output logic [TW-1:0] tag_o
);

  logic [DW:0]   trial;
  logic [DW+1:0] diff;
  logic          qbit;
  logic          valid_q;
  logic [QW-1:0] n_q;
  logic [DW-1:0] r_q, d_q;
  logic [TW-1:0] tag_q;

  // Shift the next numerator bit into the partial remainder and try the divisor.
  assign trial = {r_i, n_i[QW-1]};
  assign diff  = {1'b0, trial} - {2'b00, d_i};
  assign qbit  = ~diff[DW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q   <= {n_i[QW-2:0], qbit};
      r_q   <= qbit ? diff[DW-1:0] : trial[DW-1:0];
      d_q   <= d_i;
      tag_q <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign n_o     = n_q;
  assign r_o     = r_q;
  assign d_o     = d_q;
  assign tag_o   = tag_q;

endmodule

/* hw/rtl/fixed_point_alu_q24_8.sv */
// ---------------------------------------------------------------------------
// Q24.8 fixed-point ALU
// Signed fixed-point add/sub, multiply, divide, compare, min/max, inc/dec, convert.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  req     | in        | req_valid_i / req_ready_o  | req_i (kind, operand_a, operand_b)
//  rsp     | out       | rsp_valid_o / rsp_ready_i  | rsp_o (result, compare_true, ...)
//
// A request passes through a decode stage, one stage per quotient bit of the
// restoring divider, and the output register. Every operation takes the same
// path, so one request enters per cycle unless a stalled response holds the pipeline.
// Reset clears only the valid bits of each stage.
// A stalled response freezes the whole pipeline; nothing is dropped or repeated.
module fixed_point_alu_q24_8 import fpa_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 8,
  parameter int unsigned DATA_WIDTH    = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  fpa_req_t req_i,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output fpa_rsp_t rsp_o
);

`include "assert_macros.svh"

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned QW = DW + F;
  // Tag carried beside the divider: kind, simple result, product, cmp, dz, neg.
  localparam int unsigned TW = 4 + 2 * DW + 3;

  // Advance every stage when the output register is free or being drained.
  logic adv;
  assign adv         = !rsp_valid_o || rsp_ready_i;
  assign req_ready_o = adv;

  // ---------------- decode stage ----------------
  logic [63:0]          a_ext, b_ext;
  logic signed [DW-1:0] a_s, b_s;
  logic [DW-1:0]        mag_a, mag_b;
  logic                 lt_ab, lt_ba, eq_ab;
  logic [DW-1:0]        simple_d;
  logic                 cmp_d, dz_d, neg_d;
  logic signed [2*DW-1:0] prod;
  fpa_op_e              op;

  assign a_ext = 64'(req_i.operand_a);
  assign b_ext = 64'(req_i.operand_b);
  assign a_s   = signed'(a_ext[DW-1:0]);
  assign b_s   = signed'(b_ext[DW-1:0]);
  assign op    = fpa_op_e'(req_i.kind);

  assign lt_ab = a_s < b_s;
  assign lt_ba = b_s < a_s;
  assign eq_ab = a_s == b_s;
  assign mag_a = a_s[DW-1] ? DW'(-a_s) : DW'(a_s);
  assign mag_b = b_s[DW-1] ? DW'(-b_s) : DW'(b_s);
  assign neg_d = a_s[DW-1] ^ b_s[DW-1];
  assign prod  = (2*DW)'(a_s) * (2*DW)'(b_s);

  always_comb begin
    simple_d = '0;
    cmp_d    = 1'b0;
    dz_d     = 1'b0;
    case (op)
      OP_ADD:      simple_d = DW'(a_s + b_s);
      OP_SUB:      simple_d = DW'(a_s - b_s);
      OP_DIV:      dz_d     = (b_s == '0);
      OP_GT:       cmp_d    = lt_ba;
      OP_LT:       cmp_d    = lt_ab;
      OP_GE:       cmp_d    = !lt_ab;
      OP_LE:       cmp_d    = !lt_ba;
      OP_EQ:       cmp_d    = eq_ab;
      OP_NE:       cmp_d    = !eq_ab;
      OP_MIN:      simple_d = lt_ab ? a_s : b_s;
      OP_MAX:      simple_d = lt_ba ? a_s : b_s;
      OP_INC:      simple_d = DW'(a_s + 1'b1);
      OP_DEC:      simple_d = DW'(a_s - 1'b1);
      OP_FROM_INT: simple_d = DW'(a_s <<< F);
      OP_TO_INT:   simple_d = DW'(a_s >>> F);
      default:     simple_d = '0;
    endcase
  end

  logic          dec_valid_q;
  logic [QW-1:0] dec_n_q;
  logic [DW-1:0] dec_d_q;
  logic [TW-1:0] dec_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_valid_q <= 1'b0;
    end else if (adv) begin
      dec_valid_q <= req_valid_i;
    end
  end

  // Hold the product bits above the fraction; the divider sees |a| << F.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dec_n_q   <= {mag_a, F'(0)};
      dec_d_q   <= mag_b;
      dec_tag_q <= {req_i.kind, simple_d, prod[DW+F-1:F], cmp_d, dz_d, neg_d};
    end
  end

  // ---------------- divider chain ----------------
  logic          st_valid [QW+1];
  logic [QW-1:0] st_n     [QW+1];
  logic [DW-1:0] st_r     [QW+1];
  logic [DW-1:0] st_d     [QW+1];
  logic [TW-1:0] st_tag   [QW+1];

  assign st_valid[0] = dec_valid_q;
  assign st_n[0]     = dec_n_q;
  assign st_r[0]     = '0;
  assign st_d[0]     = dec_d_q;
  assign st_tag[0]   = dec_tag_q;

  for (genvar i = 0; i < QW; i++) begin : g_div
    fpa_div_step #(.DW(DW), .QW(QW), .TW(TW)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (st_valid[i]),
      .n_i     (st_n[i]),
      .r_i     (st_r[i]),
      .d_i     (st_d[i]),
      .tag_i   (st_tag[i]),
      .valid_o (st_valid[i+1]),
      .n_o     (st_n[i+1]),
      .r_o     (st_r[i+1]),
      .d_o     (st_d[i+1]),
      .tag_o   (st_tag[i+1])
    );
  end

  // ---------------- output stage ----------------
  logic [3:0]    t_kind;
  logic [DW-1:0] t_simple, t_mul;
  logic          t_cmp, t_dz, t_neg;
  logic [QW-1:0] quo;
  logic [DW-1:0] res_w;
  logic [63:0]   res_ext;
  fpa_rsp_t      rsp_d, rsp_q;
  logic          rsp_valid_q;

  assign {t_kind, t_simple, t_mul, t_cmp, t_dz, t_neg} = st_tag[QW];
  // Apply the sign to the magnitude quotient and wrap to the data width.
  assign quo = t_neg ? QW'(-st_n[QW]) : st_n[QW];

  always_comb begin
    case (fpa_op_e'(t_kind))
      OP_MUL:  res_w = t_mul;
      OP_DIV:  res_w = t_dz ? '0 : quo[DW-1:0];
      default: res_w = t_simple;
    endcase
  end

  assign res_ext              = 64'(signed'(res_w));
  assign rsp_d.result         = res_ext[31:0];
  assign rsp_d.compare_true   = t_cmp;
  assign rsp_d.divide_by_zero = t_dz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (adv) begin
      rsp_valid_q <= st_valid[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // ---------------- assertions ----------------
  `FPA_ASSERT(a_dz_zero, rsp_valid_o && rsp_o.divide_by_zero |-> rsp_o.result == '0, "dz result not zero")
  `FPA_ASSERT(a_cmp_zero, rsp_valid_o && rsp_o.compare_true |-> rsp_o.result == '0, "compare result not zero")
  `FPA_ASSERT(a_flags_excl, rsp_valid_o |-> !(rsp_o.compare_true && rsp_o.divide_by_zero), "both flags set")
  `FPA_ASSERT(a_stall_cause, !req_ready_o |-> rsp_valid_o && !rsp_ready_i, "stall without blocked output")

endmodule
